// ===== rtl/alsse_pkg.sv =====
// ----------------------------------------------------------------------------
// alsse_pkg
// Types and codes shared by the ordered list engine and its checker.
// ----------------------------------------------------------------------------
package alsse_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_READ   = 3'd2,
      OP_SEARCH = 3'd3,
      OP_SORT   = 3'd4,
      OP_INSERT = 3'd5,
      OP_DELETE = 3'd6,
      OP_NONE   = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] operand_value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] element_value;
      logic [5:0]         element_index;
      logic [6:0]         entry_count;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/array_list_sort_search_engine_top.sv =====
// ----------------------------------------------------------------------------
// array_list_sort_search_engine_top
// Ordered list of signed words in one memory, worked by a small sequencer.
// ----------------------------------------------------------------------------
// clear/append/errors answer the cycle after the request beat; read-out and search
// walk the list one entry at a time (one memory read port); insert/delete shift
// the moved entries one at a time; sort runs bubble passes, comparing each
// adjacent pair and swapping it when out of order.
// one item at a time, req_ready low while busy.
// reset: synchronous, clears the count and sequencer; memory needs no clearing.
module array_list_sort_search_engine_top #(
   parameter int DEPTH = alsse_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  alsse_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output alsse_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(DEPTH);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RD    = 8'b0000_0010,
      S_RDW   = 8'b0000_0100,
      S_SCH   = 8'b0000_1000,
      S_SWA   = 8'b0001_0000,
      S_SWB   = 8'b0010_0000,
      S_SHIFT = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   // read phase, then compare/write phase for each walk step
   state_type          state_ff, state_in;
   alsse_pkg::req_type req_ff, req_in;
   logic [6:0]         count_ff, count_in;
   logic [6:0]         idx_ff, idx_in;
   logic [6:0]         lim_ff, lim_in;
   logic               found_ff, found_in;
   logic signed [31:0] held_ff, held_in;
   logic               rv_ff, rv_in;
   alsse_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0]        mem [DEPTH];
   logic [31:0]        rd_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   function automatic alsse_pkg::rsp_type mk(alsse_pkg::status_type s,
         logic [31:0] v, logic [6:0] i, logic [6:0] c, logic l);
      alsse_pkg::rsp_type r;
      r.status = s; r.element_value = v; r.element_index = i[5:0];
      r.entry_count = c; r.last = l;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff; req_in = req_ff; count_in = count_ff;
      idx_in = idx_ff; lim_in = lim_ff; found_in = found_ff;
      held_in = held_ff; rv_in = rv_ff; rsp_in = rsp_ff;
      rd_addr = idx_ff[AW-1:0]; wr_en = 1'b0; wr_addr = idx_ff[AW-1:0];
      wr_data = held_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               idx_in = '0;
               found_in = 1'b0;
               case (req_data.opcode)
                  alsse_pkg::OP_CLEAR: begin
                     count_in = '0;
                     rsp_in = mk(alsse_pkg::ST_OK, '0, '0, '0, 1'b1);
                     rv_in = 1'b1;
                  end
                  alsse_pkg::OP_APPEND: begin
                     if (count_ff >= 7'(DEPTH)) begin
                        rsp_in = mk(alsse_pkg::ST_FULL, '0, '0, count_ff, 1'b1);
                     end else begin
                        wr_en = 1'b1; wr_addr = count_ff[AW-1:0];
                        wr_data = req_data.operand_value;
                        count_in = count_ff + 7'd1;
                        rsp_in = mk(alsse_pkg::ST_OK, req_data.operand_value,
                                    count_ff, count_ff + 7'd1, 1'b1);
                     end
                     rv_in = 1'b1;
                  end
                  alsse_pkg::OP_READ, alsse_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_in = (req_data.opcode == alsse_pkg::OP_READ) ?
                           mk(alsse_pkg::ST_OK, '0, '0, '0, 1'b1) :
                           mk(alsse_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
                        rv_in = 1'b1;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  alsse_pkg::OP_SORT: begin
                     if (count_ff < 7'd2) begin
                        rsp_in = mk(alsse_pkg::ST_OK, '0, '0, count_ff, 1'b1);
                        rv_in = 1'b1;
                     end else begin
                        lim_in = count_ff - 7'd1;
                        state_in = S_SWA;
                     end
                  end
                  alsse_pkg::OP_INSERT: begin
                     if (req_data.position > count_ff) begin
                        rsp_in = mk(alsse_pkg::ST_BAD_POS, '0, '0, count_ff, 1'b1);
                        rv_in = 1'b1;
                     end else if (count_ff >= 7'(DEPTH)) begin
                        rsp_in = mk(alsse_pkg::ST_FULL, '0, '0, count_ff, 1'b1);
                        rv_in = 1'b1;
                     end else begin
                        idx_in = count_ff;
                        state_in = S_SHIFT;
                     end
                  end
                  alsse_pkg::OP_DELETE: begin
                     if (req_data.position >= count_ff) begin
                        rsp_in = mk(alsse_pkg::ST_BAD_POS, '0, '0, count_ff, 1'b1);
                        rv_in = 1'b1;
                     end else begin
                        idx_in = req_data.position;
                        state_in = S_SHIFT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            // address idx presented, data in rd_ff next cycle
            state_in = (req_ff.opcode == alsse_pkg::OP_READ) ? S_RDW : S_SCH;
         end
         S_RDW: begin
            if (!rv_ff) begin
               rsp_in = mk(alsse_pkg::ST_OK, rd_ff, idx_ff, count_ff,
                           idx_ff + 7'd1 == count_ff);
               rv_in = 1'b1;
               idx_in = idx_ff + 7'd1;
               state_in = (idx_ff + 7'd1 == count_ff) ? S_OUT : S_RD;
            end
         end
         S_SCH: begin
            if (idx_ff + 7'd1 == count_ff) begin
               // final compare: hold until output slot free
               if (!rv_ff) begin
                  if (rd_ff == req_ff.operand_value) begin
                     rsp_in = mk(alsse_pkg::ST_OK, rd_ff, idx_ff, count_ff, 1'b1);
                  end else if (found_ff) begin
                     // a match was held back; emit it as last
                     rsp_in = mk(alsse_pkg::ST_OK, held_ff, lim_ff, count_ff, 1'b1);
                  end else begin
                     rsp_in = mk(alsse_pkg::ST_NOT_FOUND, '0, '0, count_ff, 1'b1);
                  end
                  if (rd_ff == req_ff.operand_value && found_ff) begin
                     rsp_in = mk(alsse_pkg::ST_OK, held_ff, lim_ff, count_ff, 1'b0);
                     lim_in = idx_ff; held_in = rd_ff;
                     state_in = S_OUT; found_in = 1'b1;
                     idx_in = 7'd127;
                  end else begin
                     state_in = S_OUT; found_in = 1'b0;
                  end
                  rv_in = 1'b1;
               end
            end else if (rd_ff == req_ff.operand_value) begin
               // hold one match back so the last flag can be set later
               if (!found_ff) begin
                  found_in = 1'b1; held_in = rd_ff; lim_in = idx_ff;
                  idx_in = idx_ff + 7'd1; state_in = S_RD;
               end else if (!rv_ff) begin
                  rsp_in = mk(alsse_pkg::ST_OK, held_ff, lim_ff, count_ff, 1'b0);
                  rv_in = 1'b1;
                  held_in = rd_ff; lim_in = idx_ff;
                  idx_in = idx_ff + 7'd1; state_in = S_RD;
               end
            end else begin
               idx_in = idx_ff + 7'd1; state_in = S_RD;
            end
         end
         S_SWA: begin
            // read entry idx (held), then entry idx+1
            if (!found_ff) begin
               found_in = 1'b1;
            end else begin
               held_in = rd_ff;
               found_in = 1'b0;
               rd_addr = AW'(idx_ff + 7'd1);
               state_in = S_SWB;
            end
         end
         S_SWB: begin
            if (!found_ff) begin
               rd_addr = AW'(idx_ff + 7'd1);
               found_in = 1'b1;
            end else begin
               found_in = 1'b0;
               if ($signed(held_ff) > $signed(rd_ff)) begin
                  wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_ff;
                  held_in = held_ff;
                  idx_in = idx_ff + 7'd1;
               end else begin
                  idx_in = idx_ff + 7'd1;
               end
               // pending high write goes to idx+1 next
               state_in = S_SWB;
               if ($signed(held_ff) > $signed(rd_ff)) begin
                  found_in = 1'b1; // re-enter with swap pending
                  state_in = S_SHIFT;
               end else if (idx_ff + 7'd1 >= lim_ff) begin
                  state_in = S_SWA; idx_in = '0;
                  lim_in = lim_ff - 7'd1;
                  if (lim_ff == 7'd1) begin
                     rsp_in = mk(alsse_pkg::ST_OK, '0, '0, count_ff, 1'b1);
                     rv_in = 1'b1; state_in = S_OUT; idx_in = 7'd127;
                  end
               end else begin
                  held_in = rd_ff;
               end
            end
         end
         S_SHIFT: begin
            if (req_ff.opcode == alsse_pkg::OP_SORT) begin
               // finish swap: larger value lands at idx
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = held_ff;
               found_in = 1'b0;
               if (idx_ff >= lim_ff) begin
                  idx_in = '0; lim_in = lim_ff - 7'd1; state_in = S_SWA;
                  if (lim_ff == 7'd1) begin
                     rsp_in = mk(alsse_pkg::ST_OK, '0, '0, count_ff, 1'b1);
                     rv_in = 1'b1; state_in = S_OUT; idx_in = 7'd127;
                  end
               end else begin
                  state_in = S_SWB;
               end
            end else if (req_ff.opcode == alsse_pkg::OP_INSERT) begin
               if (idx_ff == req_ff.position) begin
                  wr_en = 1'b1; wr_data = req_ff.operand_value;
                  count_in = count_ff + 7'd1;
                  rsp_in = mk(alsse_pkg::ST_OK, req_ff.operand_value, idx_ff,
                              count_ff + 7'd1, 1'b1);
                  rv_in = 1'b1; state_in = S_OUT; idx_in = 7'd127;
               end else begin
                  rd_addr = AW'(idx_ff - 7'd1);
                  if (!found_ff) begin
                     found_in = 1'b1;
                  end else begin
                     wr_en = 1'b1; wr_data = rd_ff;
                     found_in = 1'b0; idx_in = idx_ff - 7'd1;
                  end
               end
            end else begin
               // delete: first read captures the removed entry
               if (!found_ff) begin
                  found_in = 1'b1;
                  lim_in = 7'd0;
               end else if (lim_ff == 7'd0) begin
                  held_in = rd_ff; lim_in = 7'd1;
                  if (idx_ff + 7'd1 >= count_ff) begin
                     count_in = count_ff - 7'd1;
                     rsp_in = mk(alsse_pkg::ST_OK, rd_ff, req_ff.position,
                                 count_ff - 7'd1, 1'b1);
                     found_in = 1'b0;
                     rv_in = 1'b1; state_in = S_OUT; idx_in = 7'd127;
                  end
               end else begin
                  rd_addr = AW'(idx_ff + 7'd1);
                  if (lim_ff == 7'd1) begin
                     lim_in = 7'd2;
                  end else begin
                     wr_en = 1'b1; wr_data = rd_ff; lim_in = 7'd1;
                     idx_in = idx_ff + 7'd1;
                     if (idx_ff + 7'd2 >= count_ff) begin
                        count_in = count_ff - 7'd1;
                        rsp_in = mk(alsse_pkg::ST_OK, held_ff, req_ff.position,
                                    count_ff - 7'd1, 1'b1);
                        found_in = 1'b0;
                        rv_in = 1'b1; state_in = S_OUT; idx_in = 7'd127;
                     end
                  end
               end
            end
         end
         S_OUT: begin
            if (idx_ff != 7'd127 || !found_ff) begin
               if (!rv_in) begin
                  state_in = S_IDLE;
               end
            end else if (!rv_ff) begin
               rsp_in = mk(alsse_pkg::ST_OK, held_ff, lim_ff, count_ff, 1'b1);
               rv_in = 1'b1; found_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         found_ff <= found_in;
      end
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      lim_ff  <= lim_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== rtl/alsse_checker.sv =====
// ----------------------------------------------------------------------------
// alsse_checker
// Port-level checks of the ordered list engine.
// ----------------------------------------------------------------------------
module alsse_props (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input alsse_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input alsse_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result waits");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 7'd64)
      else $error("entry count out of range");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != alsse_pkg::ST_OK |-> rsp_data.last)
      else $error("error beat not last");
endmodule

bind array_list_sort_search_engine_top alsse_props u_alsse_props (.*);
